>>> hdl/biu_pkg.sv
// ----------------------------------------------------------------------------
// biu_pkg
// Shared widths, codes and helpers for the bilinear image upscaler.
// ----------------------------------------------------------------------------
package biu_pkg;

  // default sizing
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_COLS  = 256;
  localparam int DEF_MAX_SCALE = 8;

  // stream payload layout
  localparam int COORD_W    = 11;
  localparam int CH_W       = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int DIM_REG_W   = 9;
  localparam int SCALE_REG_W = 4;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ROWS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_COLS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic [DIM_REG_W-1:0]   RST_SOURCE_ROWS  = 9'd256;
  localparam logic [DIM_REG_W-1:0]   RST_SOURCE_COLS  = 9'd256;
  localparam logic [SCALE_REG_W-1:0] RST_SCALE_FACTOR = 4'd3;

  // command codes carried in tuser
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int unsigned clamp_u(int unsigned v, int unsigned hi);
    if (v == 0) begin
      return 1;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

>>> hdl/bilinear_image_upscaler.sv
// ----------------------------------------------------------------------------
// bilinear_image_upscaler
// Stores an RGB source image and returns pixels of its bilinear enlargement.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries commands. tuser = 0 writes the source pixel
// (row, col) with its red, green and blue bytes and produces no result;
// tuser = 1 requests output pixel (row, col) of the image enlarged by the
// configured scale factor and produces exactly one master stream transaction.
// A request outside the enlarged image returns zero colors with tuser = 1.
// Sizes and scale come from the cfg_we / cfg_index / cfg_data write port.
// The next command can be taken once the result is registered. The sequencer
// runs one command at a time; a single restoring divider, one bit per cycle,
// performs the row and column divisions and the three channel normalizations,
// and the four neighbors come from a single-port pixel memory one per cycle.
// The finished result sits in an output register; writes are still taken
// while it waits, a following request completes and holds until the receiver
// takes the earlier one. Reset sets the registers to 256 x 256, scale 3, and
// clears the control logic; pixel memory contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_image_upscaler #(
  parameter int MAX_ROWS  = biu_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = biu_pkg::DEF_MAX_COLS,
  parameter int MAX_SCALE = biu_pkg::DEF_MAX_SCALE
) (
  input  logic                             clk,
  input  logic                             rst,
  // command input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // row[10:0], col[21:11], red_in[29:22], green_in[37:30], blue_in[45:38]
  input  logic [biu_pkg::IN_DATA_W-1:0]    s_tdata,
  // command[0]
  input  logic                             s_tuser,
  // result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [biu_pkg::OUT_DATA_W-1:0]   m_tdata,
  // range_error[0]
  output logic                             m_tuser,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [biu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [biu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import biu_pkg::*;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int SC_W   = $clog2(MAX_SCALE + 1);
  localparam int SS_W   = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int SUM_W  = CH_W + SS_W;
  localparam int DIV_W  = (SUM_W > COORD_W) ? SUM_W : COORD_W;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int ORR_W  = RW + SC_W;
  localparam int ORC_W  = CW + SC_W;
  localparam int CMPR_W = (ORR_W > COORD_W) ? ORR_W : COORD_W;
  localparam int CMPC_W = (ORC_W > COORD_W) ? ORC_W : COORD_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam logic [2:0] LAST_STEP = 3'd4;
  localparam logic [1:0] LAST_CH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_PREP,
    ST_READ,
    ST_DIV_CH,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [DIM_REG_W-1:0]   source_rows;
  logic [DIM_REG_W-1:0]   source_cols;
  logic [SCALE_REG_W-1:0] scale_factor;
  logic [RW-1:0]          rows_c;
  logic [CW-1:0]          cols_c;
  logic [SC_W-1:0]        s_c;

  // captured command
  logic                   cmd_q;
  logic [COORD_W-1:0]     row_q;
  logic [COORD_W-1:0]     col_q;
  logic [3*CH_W-1:0]      pix_q;

  // interpolation state
  logic [ROW_W-1:0]       y0;
  logic [COL_W-1:0]       x0;
  logic [SC_W-1:0]        fy;
  logic [SC_W-1:0]        fx;
  logic                   last_r;
  logic                   last_c;
  logic [SS_W-1:0]        ss_q;
  logic [2:0]             rd_step;
  logic                   rd_vld;
  logic                   use_q;
  logic [SS_W-1:0]        w_q;
  logic [SUM_W-1:0]       acc [3];
  logic [SUM_W-1:0]       acc_next [3];
  logic [1:0]             ch;
  logic [CH_W-1:0]        res [3];
  logic                   err_q;

  // shared divider
  logic [DIV_W-1:0]       div_num;
  logic [SS_W-1:0]        div_rem;
  logic [SS_W-1:0]        div_den;
  logic [CNT_W-1:0]       div_cnt;
  logic [SS_W:0]          div_trial;
  logic                   div_ge;
  logic [DIV_W-1:0]       div_num_next;
  logic [SS_W-1:0]        div_rem_next;
  logic                   div_last;

  // memory
  logic [3*CH_W-1:0]      mem [DEPTH];
  logic [3*CH_W-1:0]      rd_data;
  logic [AW-1:0]          mem_addr;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;

  // combinational helpers
  logic [ORR_W-1:0]       out_rows;
  logic [ORC_W-1:0]       out_cols;
  logic                   req_oor;
  logic                   wr_in_src;
  logic                   last_r_next;
  logic                   last_c_next;
  logic [SC_W-1:0]        fxe;
  logic [SC_W-1:0]        fye;
  logic [SC_W-1:0]        wx;
  logic [SC_W-1:0]        wy;
  logic [2*SC_W-1:0]      w_full;
  logic [2*SC_W-1:0]      ss_full;
  logic [ROW_W-1:0]       rd_y;
  logic [COL_W-1:0]       rd_x;
  logic                   rd_use;
  logic                   rd_issue;
  logic [3*CH_W-1:0]      nb_pix;

  assign rows_c = RW'(clamp_u(32'(source_rows), MAX_ROWS));
  assign cols_c = CW'(clamp_u(32'(source_cols), MAX_COLS));
  assign s_c    = SC_W'(clamp_u(32'(scale_factor), MAX_SCALE));

  assign s_tready = (state == ST_IDLE);

  // range and bounds checks
  assign out_rows  = ORR_W'(rows_c) * ORR_W'(s_c);
  assign out_cols  = ORC_W'(cols_c) * ORC_W'(s_c);
  assign req_oor   = (CMPR_W'(row_q) >= CMPR_W'(out_rows)) ||
                     (CMPC_W'(col_q) >= CMPC_W'(out_cols));
  assign wr_in_src = (CMPR_W'(row_q) < CMPR_W'(rows_c)) &&
                     (CMPC_W'(col_q) < CMPC_W'(cols_c));

  assign last_r_next = (RW'(y0) + RW'(1)) >= rows_c;
  assign last_c_next = (CW'(x0) + CW'(1)) >= cols_c;

  // divider step: one quotient bit per cycle
  always_comb begin
    div_trial    = {div_rem, div_num[DIV_W-1]};
    div_ge       = div_trial >= {1'b0, div_den};
    div_rem_next = div_ge ? SS_W'(div_trial - {1'b0, div_den}) : div_trial[SS_W-1:0];
    div_num_next = {div_num[DIV_W-2:0], div_ge};
    div_last     = (div_cnt == CNT_W'(DIV_W - 1));
  end

  // neighbor selection and weight for the current read step
  // edge rows and columns zero the fractional part, which reduces the blend
  always_comb begin
    fxe      = last_c ? '0 : fx;
    fye      = last_r ? '0 : fy;
    wx       = rd_step[0] ? fxe : SC_W'(s_c - fxe);
    wy       = rd_step[1] ? fye : SC_W'(s_c - fye);
    w_full   = (2*SC_W)'(wx) * (2*SC_W)'(wy);
    ss_full  = (2*SC_W)'(s_c) * (2*SC_W)'(s_c);
    rd_y     = (rd_step[1] && !last_r) ? ROW_W'(y0 + ROW_W'(1)) : y0;
    rd_x     = (rd_step[0] && !last_c) ? COL_W'(x0 + COL_W'(1)) : x0;
    rd_use   = (!rd_step[0] || !last_c) && (!rd_step[1] || !last_r);
    rd_issue = !rd_step[2];
    rd_addr  = AW'(rd_y) * AW'(MAX_COLS) + AW'(rd_x);
    wr_addr  = AW'(row_q[ROW_W-1:0]) * AW'(MAX_COLS) + AW'(col_q[COL_W-1:0]);
    mem_we   = (state == ST_DECODE) && (cmd_q == CMD_WRITE) && wr_in_src;
    mem_addr = (state == ST_READ) ? rd_addr : wr_addr;
    nb_pix   = use_q ? rd_data : '0;
    for (int i = 0; i < 3; i++) begin
      acc_next[i] = acc[i] +
                    SUM_W'(nb_pix[(2-i)*CH_W +: CH_W]) * SUM_W'(w_q);
    end
  end

  // single-port pixel memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= pix_q;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      source_rows  <= RST_SOURCE_ROWS;
      source_cols  <= RST_SOURCE_COLS;
      scale_factor <= RST_SCALE_FACTOR;
      m_tvalid     <= 1'b0;
      div_cnt      <= '0;
      rd_step      <= '0;
      rd_vld       <= 1'b0;
      ch           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOURCE_ROWS:  source_rows  <= cfg_data[DIM_REG_W-1:0];
          REG_SOURCE_COLS:  source_cols  <= cfg_data[DIM_REG_W-1:0];
          REG_SCALE_FACTOR: scale_factor <= cfg_data[SCALE_REG_W-1:0];
          default: ;
        endcase
      end

      // the finish state reloads the output register on its own
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= s_tuser;
            row_q <= s_tdata[10:0];
            col_q <= s_tdata[21:11];
            pix_q <= {s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          if (cmd_q == CMD_WRITE) begin
            state <= ST_IDLE;
          end else if (req_oor) begin
            err_q  <= 1'b1;
            res[0] <= '0;
            res[1] <= '0;
            res[2] <= '0;
            state  <= ST_FINISH;
          end else begin
            err_q   <= 1'b0;
            div_num <= DIV_W'(row_q);
            div_rem <= '0;
            div_den <= SS_W'(s_c);
            div_cnt <= '0;
            state   <= ST_DIV_ROW;
          end
        end

        ST_DIV_ROW: begin
          if (div_last) begin
            y0      <= div_num_next[ROW_W-1:0];
            fy      <= div_rem_next[SC_W-1:0];
            div_num <= DIV_W'(col_q);
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV_COL;
          end else begin
            div_num <= div_num_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt + CNT_W'(1);
          end
        end

        ST_DIV_COL: begin
          if (div_last) begin
            x0      <= div_num_next[COL_W-1:0];
            fx      <= div_rem_next[SC_W-1:0];
            div_cnt <= '0;
            state   <= ST_PREP;
          end else begin
            div_num <= div_num_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt + CNT_W'(1);
          end
        end

        ST_PREP: begin
          last_r  <= last_r_next;
          last_c  <= last_c_next;
          ss_q    <= ss_full[SS_W-1:0];
          acc[0]  <= '0;
          acc[1]  <= '0;
          acc[2]  <= '0;
          rd_step <= '0;
          rd_vld  <= 1'b0;
          state   <= ST_READ;
        end

        ST_READ: begin
          // read issued one cycle, weighted and summed the next
          rd_vld <= rd_issue;
          w_q    <= w_full[SS_W-1:0];
          use_q  <= rd_use;
          if (rd_vld) begin
            acc[0] <= acc_next[0];
            acc[1] <= acc_next[1];
            acc[2] <= acc_next[2];
          end
          if (rd_step == LAST_STEP) begin
            rd_step <= '0;
            div_num <= DIV_W'(acc_next[0]);
            div_rem <= '0;
            div_den <= ss_q;
            div_cnt <= '0;
            ch      <= '0;
            state   <= ST_DIV_CH;
          end else begin
            rd_step <= rd_step + 3'd1;
          end
        end

        ST_DIV_CH: begin
          if (div_last) begin
            res[ch] <= div_num_next[CH_W-1:0];
            div_rem <= '0;
            div_cnt <= '0;
            if (ch == LAST_CH) begin
              ch    <= '0;
              state <= ST_FINISH;
            end else begin
              div_num <= DIV_W'(acc[ch + 2'd1]);
              ch      <= ch + 2'd1;
            end
          end else begin
            div_num <= div_num_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt + CNT_W'(1);
          end
        end

        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res[2], res[1], res[0]};
            m_tuser  <= err_q;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // out-of-range results never carry color
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("range error result with nonzero color");

  // the divider counter only advances inside a division
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV_ROW && state != ST_DIV_COL && state != ST_DIV_CH) |->
      div_cnt == '0)
    else $error("divider count moved outside a division");

  // read data is only weighted while the neighbor fetch runs
  a_rd_window: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ST_READ)
    else $error("neighbor data valid outside fetch");

  // a new result appears only at the end of a request
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH && $past(cmd_q) == CMD_REQUEST)
    else $error("result produced without a request");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear image upscaler: source pixel writes and
// output pixel requests go in on the slave stream, and every result on the
// master stream is checked against a bit-true interpolation model. The run
// walks through several image sizes and scale factors, the clamped ones
// among them, with random backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import biu_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int DRAIN_SLACK   = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 80;
  localparam int STORE_DEPTH   = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int REPORT_LIMIT  = 10;
  // index past the last register, must be ignored by the block
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
  } upscale_cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            range_err;
  } pixel_result_t;

  class upscale_scoreboard;
    logic [3*CH_W-1:0] pixels [0:STORE_DEPTH-1];
    logic [DIM_REG_W-1:0]   rows_reg;
    logic [DIM_REG_W-1:0]   cols_reg;
    logic [SCALE_REG_W-1:0] scale_reg;
    pixel_result_t expected_q[$];
    int errors;

    function new();
      rows_reg  = RST_SOURCE_ROWS;
      cols_reg  = RST_SOURCE_COLS;
      scale_reg = RST_SCALE_FACTOR;
      errors    = 0;
    endfunction

    function int unsigned bounded(int unsigned v, int unsigned hi);
      if (v < 1) begin
        return 1;
      end
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned eff_rows();
      return bounded(rows_reg, DEF_MAX_ROWS);
    endfunction

    function int unsigned eff_cols();
      return bounded(cols_reg, DEF_MAX_COLS);
    endfunction

    function int unsigned eff_scale();
      return bounded(scale_reg, DEF_MAX_SCALE);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SOURCE_ROWS:  rows_reg  = data[DIM_REG_W-1:0];
        REG_SOURCE_COLS:  cols_reg  = data[DIM_REG_W-1:0];
        REG_SCALE_FACTOR: scale_reg = data[SCALE_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // store a source write, or predict a request: zero with range error outside, else a blend of the four neighbors
    function void note_command(upscale_cmd_t c);
      int unsigned rows, cols, s, y0, x0, fy, fx, a, b, cc, d, v;
      bit last_r, last_c;
      logic [3*CH_W-1:0] p00, p01, p10, p11;
      logic [CH_W-1:0] ch [3];
      pixel_result_t res;
      rows = eff_rows();
      cols = eff_cols();
      s    = eff_scale();
      if (c.cmd == CMD_WRITE) begin
        if (c.row < rows && c.col < cols) begin
          pixels[c.row * DEF_MAX_COLS + c.col] = {c.red, c.green, c.blue};
        end
        return;
      end
      if (c.row >= rows * s || c.col >= cols * s) begin
        res = '{red: '0, green: '0, blue: '0, range_err: 1'b1};
        expected_q.push_back(res);
        return;
      end
      y0 = c.row / s;
      fy = c.row % s;
      x0 = c.col / s;
      fx = c.col % s;
      last_r = (y0 + 1 >= rows);
      last_c = (x0 + 1 >= cols);
      p00 = pixels[y0 * DEF_MAX_COLS + x0];
      p01 = last_c ? '0 : pixels[y0 * DEF_MAX_COLS + x0 + 1];
      p10 = last_r ? '0 : pixels[(y0 + 1) * DEF_MAX_COLS + x0];
      p11 = (last_r || last_c) ? '0 : pixels[(y0 + 1) * DEF_MAX_COLS + x0 + 1];
      for (int n = 0; n < 3; n++) begin
        a  = p00[3*CH_W-1-CH_W*n -: CH_W];
        b  = p01[3*CH_W-1-CH_W*n -: CH_W];
        cc = p10[3*CH_W-1-CH_W*n -: CH_W];
        d  = p11[3*CH_W-1-CH_W*n -: CH_W];
        if (last_r && last_c) begin
          v = a;
        end else if (last_r) begin
          v = (a * (s - fx) + b * fx) / s;
        end else if (last_c) begin
          v = (a * (s - fy) + cc * fy) / s;
        end else begin
          v = (a * (s - fx) * (s - fy) + b * fx * (s - fy) +
               cc * (s - fx) * fy + d * fx * fy) / (s * s);
        end
        ch[n] = v[CH_W-1:0];
      end
      res = '{red: ch[0], green: ch[1], blue: ch[2], range_err: 1'b0};
      expected_q.push_back(res);
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("[%0t] unexpected result r=%h g=%h b=%h err=%b",
                   $realtime, got.red, got.green, got.blue, got.range_err);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.range_err !== want.range_err) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("[%0t] mismatch: expected r=%h g=%h b=%h err=%b, got r=%h g=%h b=%h err=%b",
                   $realtime, want.red, want.green, want.blue, want.range_err,
                   got.red, got.green, got.blue, got.range_err);
        end
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata   = '0;
  logic                    s_tuser   = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    m_tuser;
  logic                    cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  upscale_scoreboard sb;
  bit filled [0:STORE_DEPTH-1];
  int items_sent    = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 84;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  bilinear_image_upscaler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_tready   <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_command(upscale_cmd_t'{cmd: s_tuser, row: s_tdata[10:0],
                                       col: s_tdata[21:11], red: s_tdata[29:22],
                                       green: s_tdata[37:30],
                                       blue: s_tdata[45:38]});
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(pixel_result_t'{red: m_tdata[7:0], green: m_tdata[15:8],
                                        blue: m_tdata[23:16], range_err: m_tuser});
      end
    end
  end

  task automatic send_cmd(upscale_cmd_t c);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, c.blue, c.green, c.red, c.col, c.row};
    s_tuser  <= c.cmd;
    items_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic stop_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic send_pixel(int unsigned row, int unsigned col,
                            logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    upscale_cmd_t c;
    c = '{cmd: CMD_WRITE, row: row[COORD_W-1:0], col: col[COORD_W-1:0],
          red: r, green: g, blue: b};
    if (row < sb.eff_rows() && col < sb.eff_cols()) begin
      filled[row * DEF_MAX_COLS + col] = 1'b1;
    end
    send_cmd(c);
  endtask

  task automatic fill_if_blank(int unsigned row, int unsigned col);
    if (!filled[row * DEF_MAX_COLS + col]) begin
      send_pixel(row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
  endtask

  // make sure every neighbor the interpolation reads holds a written pixel, then send the request
  task automatic request_pixel(int unsigned row, int unsigned col);
    int unsigned rows, cols, s, y0, x0;
    bit last_r, last_c;
    upscale_cmd_t c;
    rows = sb.eff_rows();
    cols = sb.eff_cols();
    s    = sb.eff_scale();
    if (row < rows * s && col < cols * s) begin
      y0 = row / s;
      x0 = col / s;
      last_r = (y0 + 1 >= rows);
      last_c = (x0 + 1 >= cols);
      fill_if_blank(y0, x0);
      if (!last_c) fill_if_blank(y0, x0 + 1);
      if (!last_r) fill_if_blank(y0 + 1, x0);
      if (!last_r && !last_c) fill_if_blank(y0 + 1, x0 + 1);
    end
    c = '{cmd: CMD_REQUEST, row: row[COORD_W-1:0], col: col[COORD_W-1:0],
          red: CH_W'($urandom), green: CH_W'($urandom), blue: CH_W'($urandom)};
    send_cmd(c);
  endtask

  task automatic random_item();
    int unsigned rows, cols, s, sel, row, col;
    bit rows_full, cols_full;
    rows = sb.eff_rows();
    cols = sb.eff_cols();
    s    = sb.eff_scale();
    rows_full = (rows * s > COORD_MAX);
    cols_full = (cols * s > COORD_MAX);
    sel = $urandom_range(99);
    if (sel < 50 || (sel < 60 && rows_full && cols_full)) begin
      // lean toward the last source row and column
      row = ($urandom_range(4) == 0) ? (rows - 1) * s + $urandom_range(s - 1)
                                     : $urandom_range(rows * s - 1);
      col = ($urandom_range(4) == 0) ? (cols - 1) * s + $urandom_range(s - 1)
                                     : $urandom_range(cols * s - 1);
      request_pixel(row, col);
    end else if (sel < 60) begin
      if (!rows_full && (cols_full || $urandom_range(1) == 0)) begin
        row = $urandom_range(COORD_MAX, rows * s);
        col = $urandom_range(COORD_MAX);
      end else begin
        row = $urandom_range(COORD_MAX);
        col = $urandom_range(COORD_MAX, cols * s);
      end
      request_pixel(row, col);
    end else if (sel < 88) begin
      send_pixel($urandom_range(rows - 1), $urandom_range(cols - 1),
                 CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end else begin
      // lands outside the source image and must be dropped
      if ($urandom_range(1) == 0) begin
        row = $urandom_range(COORD_MAX, rows);
        col = $urandom_range(COORD_MAX);
      end else begin
        row = $urandom_range(COORD_MAX);
        col = $urandom_range(COORD_MAX, cols);
      end
      send_pixel(row, col, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
  endtask

  initial begin
    int unsigned rows_set  [8] = '{4, 1, 0, 256, 511, 2, 3, 13};
    int unsigned cols_set  [8] = '{5, 1, 0, 256, 300, 7, 3, 6};
    int unsigned scale_set [8] = '{3, 1, 0, 8, 15, 2, 9'h1F5, 4};
    int target;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizing: 256 x 256 source, scale 3
    send_pixel(0, 0, 8'hff, 8'hff, 8'hff);
    send_pixel(0, 1, 8'h00, 8'h00, 8'h00);
    send_pixel(1, 0, 8'hff, 8'h00, 8'h80);
    send_pixel(1, 1, 8'h00, 8'hff, 8'h7f);
    send_pixel(255, 255, 8'h12, 8'h34, 8'h56);
    send_pixel(255, 254, 8'hff, 8'hff, 8'hff);
    send_pixel(254, 255, 8'h00, 8'h00, 8'h00);
    send_pixel(COORD_MAX, 0, 8'hff, 8'hff, 8'hff);
    send_pixel(0, 256, 8'haa, 8'h55, 8'hff);
    send_pixel(256, COORD_MAX, 8'h55, 8'haa, 8'h00);
    request_pixel(0, 0);
    request_pixel(1, 2);
    request_pixel(2, 1);
    request_pixel(767, 767);
    request_pixel(767, 763);
    request_pixel(763, 767);
    request_pixel(768, 0);
    request_pixel(0, COORD_MAX);
    request_pixel(COORD_MAX, COORD_MAX);
    stop_input();
    wait_drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 84;
      end else if (ph < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_reg(REG_SOURCE_ROWS, CFG_DATA_W'(rows_set[ph]));
      set_reg(REG_SOURCE_COLS, CFG_DATA_W'(cols_set[ph]));
      set_reg(REG_SCALE_FACTOR, CFG_DATA_W'(scale_set[ph]));
      if (ph == 5) begin
        set_reg(REG_UNUSED, 9'h001);
      end
      target = items_sent + PHASE_ITEMS;
      for (int k = 0; items_sent < target; k++) begin
        if (ph == 0 && k == 10) begin
          // stall the result side while commands keep coming
          @(posedge clk);
          holds_asked++;
        end
        if (ph == 4 && k == 40) begin
          stop_input();
          wait_drain();
        end
        random_item();
      end
      stop_input();
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
